// ===== src/salu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_pkg
// Shared widths, opcode and status codes, and the beat carried down the
// divider cell row.
// ----------------------------------------------------------------------------
package salu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OPCODE_W   = 4;
    localparam int STATUS_W   = 2;
    // front stage + one cell per quotient bit + output stage
    localparam int LATENCY    = DATA_WIDTH + 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_EQ  = 4'd5,
        OP_NE  = 4'd6,
        OP_LT  = 4'd7,
        OP_GT  = 4'd8,
        OP_LE  = 4'd9,
        OP_GE  = 4'd10
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_BADOP = 2'd2
    } status_t;

    typedef struct packed {
        logic                  valid;
        logic [OPCODE_W-1:0]   op;
        logic [DATA_WIDTH-1:0] res;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] dvs;
        logic                  a_neg;
        logic                  b_neg;
        logic                  b_zero;
    } salu_beat_t;

endpackage

// ===== src/salu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_front
// Input stage: add, subtract, multiply and compare results, and the operand
// magnitudes that seed the divider cell row.
// ----------------------------------------------------------------------------
module salu_front
    import salu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [OPCODE_W-1:0]          opcode,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output salu_beat_t                   beat
);

    logic                  valid_reg;
    salu_beat_t            data_reg;
    salu_beat_t            data_next;
    logic [DATA_WIDTH-1:0] mul_lo;
    logic                  lt_ab;
    logic                  lt_ba;

    assign mul_lo = DATA_WIDTH'(operand_a * operand_b);
    assign lt_ab  = operand_a < operand_b;
    assign lt_ba  = operand_b < operand_a;

    always_comb
    begin
        data_next        = '0;
        data_next.valid  = 1'b1;
        data_next.op     = opcode;
        data_next.a_neg  = operand_a[DATA_WIDTH-1];
        data_next.b_neg  = operand_b[DATA_WIDTH-1];
        data_next.b_zero = (operand_b == '0);
        data_next.rem    = '0;
        data_next.quo    = operand_a[DATA_WIDTH-1] ? DATA_WIDTH'(-operand_a)
                                                   : DATA_WIDTH'(operand_a);
        data_next.dvs    = operand_b[DATA_WIDTH-1] ? DATA_WIDTH'(-operand_b)
                                                   : DATA_WIDTH'(operand_b);
        case (opcode)
            OP_ADD: data_next.res = DATA_WIDTH'(operand_a + operand_b);
            OP_SUB: data_next.res = DATA_WIDTH'(operand_a - operand_b);
            OP_MUL: data_next.res = mul_lo;
            OP_EQ:  data_next.res = DATA_WIDTH'(operand_a == operand_b);
            OP_NE:  data_next.res = DATA_WIDTH'(operand_a != operand_b);
            OP_LT:  data_next.res = DATA_WIDTH'(lt_ab);
            OP_GT:  data_next.res = DATA_WIDTH'(lt_ba);
            OP_LE:  data_next.res = DATA_WIDTH'(!lt_ba);
            OP_GE:  data_next.res = DATA_WIDTH'(!lt_ab);
            default: data_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        beat       = data_reg;
        beat.valid = valid_reg;
    end

endmodule

// ===== src/salu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_cell
// One restoring-division step: shifts one dividend bit into the partial
// remainder, trial-subtracts the divisor and emits one quotient bit.
// ----------------------------------------------------------------------------
module salu_cell
    import salu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  salu_beat_t beat_in,
    output salu_beat_t beat_out
);

    logic                valid_reg;
    salu_beat_t          data_reg;
    salu_beat_t          data_next;
    logic [DATA_WIDTH:0] trial;
    logic [DATA_WIDTH-1:0] shifted;

    assign shifted = {beat_in.rem[DATA_WIDTH-2:0], beat_in.quo[DATA_WIDTH-1]};
    assign trial   = {1'b0, shifted} - {1'b0, beat_in.dvs};

    always_comb
    begin
        data_next     = beat_in;
        data_next.rem = trial[DATA_WIDTH] ? shifted : trial[DATA_WIDTH-1:0];
        data_next.quo = {beat_in.quo[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= beat_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_in.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        beat_out       = data_reg;
        beat_out.valid = valid_reg;
    end

endmodule

// ===== src/salu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salu_back
// Output stage: sign fix of quotient and remainder, status and truth flag.
// ----------------------------------------------------------------------------
module salu_back
    import salu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  salu_beat_t                   beat,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic                         is_true,
    output logic [STATUS_W-1:0]          status
);

    logic                  done_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic [DATA_WIDTH-1:0] result_next;
    logic                  is_true_reg;
    logic                  is_true_next;
    status_t               status_reg;
    status_t               status_next;

    always_comb
    begin
        result_next = beat.res;
        status_next = ST_OK;
        case (beat.op) inside
            OP_DIV:
            begin
                result_next = (beat.a_neg != beat.b_neg) ? DATA_WIDTH'(-beat.quo)
                                                         : beat.quo;
                if (beat.b_zero)
                begin
                    status_next = ST_DIV0;
                end
            end
            OP_MOD:
            begin
                result_next = beat.a_neg ? DATA_WIDTH'(-beat.rem) : beat.rem;
                if (beat.b_zero)
                begin
                    status_next = ST_DIV0;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_BADOP;
            end
        endcase
        if (status_next != ST_OK)
        begin
            result_next = '0;
        end
        is_true_next = (status_next == ST_OK) && (result_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.valid)
        begin
            result_reg  <= result_next;
            is_true_reg <= is_true_next;
            status_reg  <= status_next;
        end
    end

    assign done    = done_reg;
    assign result  = result_reg;
    assign is_true = is_true_reg;
    assign status  = status_reg;

endmodule

// ===== src/signed_integer_alu_with_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_alu_with_divide
// Signed ALU with add, sub, mul, div, mod and compares.
// ----------------------------------------------------------------------------
// Every operation passes through the input register, the row of one-bit
// division cells and the output register between its start beat and its done
// strobe; all opcodes take that same path, so results come out in issue
// order. busy never rises: a new beat may start in every
// cycle. done is high for one cycle with result, is_true and status; the
// receiver must take it then.
module signed_integer_alu_with_divide
    import salu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [OPCODE_W-1:0]          opcode,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic                         is_true,
    output logic [STATUS_W-1:0]          status
);

    salu_beat_t stage [0:DATA_WIDTH];
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    salu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .beat      (stage[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        salu_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (stage[i]),
            .beat_out (stage[i+1])
        );
    end

    salu_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (stage[DATA_WIDTH]),
        .done    (done),
        .result  (result),
        .is_true (is_true),
        .status  (status)
    );

`ifndef SYNTHESIS
    a_issue_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a start beat LATENCY cycles earlier");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (result == '0) && !is_true)
        else $error("error beat carries a nonzero result or truth flag");

    a_div0_source: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_DIV0) |->
            ($past(operand_b, LATENCY) == '0) &&
            (($past(opcode, LATENCY) == OP_DIV) || ($past(opcode, LATENCY) == OP_MOD)))
        else $error("divide-by-zero status without a zero divisor");

    a_ok_truth: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OK) |-> (is_true == (result != '0)))
        else $error("truth flag disagrees with result");
`endif

endmodule
